[design/triplet_angle_compatibility_macros.svh]
`ifndef TRIPLET_ANGLE_COMPATIBILITY_MACROS_SVH
`define TRIPLET_ANGLE_COMPATIBILITY_MACROS_SVH

// same-cycle implication
`define TAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[design/tac_pkg.sv]
package tac_pkg;

  localparam int MAX_OBJECTS_DEF = 64;
  localparam int MAX_LABELS_DEF  = 64;
  localparam int COORD_WIDTH_DEF = 16;

  localparam int Q_BITS = 16;
  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [15:0] MINUS_ONE_Q14 = -16'sd16384;
  localparam logic signed [16:0] SAT_POS     = 17'sd32767;

  typedef enum logic [1:0] {
    CMD_LOAD_OBJ = 2'd0,
    CMD_LOAD_LAB = 2'd1,
    CMD_QUERY    = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    T_IDLE, T_RD0, T_RD1, T_RD2, T_RD3, T_START, T_WAIT, T_FIN
  } top_state_t;

  typedef enum logic [2:0] {
    L_IDLE, L_DIFF, L_MUL, L_SUM, L_SQRT, L_DEN, L_DIV, L_DONE
  } lane_state_t;

  typedef struct packed {
    logic start;
  } lane_ctl_t;

  typedef struct packed {
    logic done;
    logic zero_len;
  } lane_status_t;

endpackage

[design/triplet_angle_compatibility.sv]
// Triplet angle compatibility: loads (command 0 object point, 1 label point) produce no
// result beat. A query returns one beat with cos(object angle) minus cos(label angle) in
// Q2.14; all-coinciding indices give zero, some coinciding or a zero-length vector -1.0.
// A query with coinciding indices finishes without touching the stores. A full query makes
// three single-port reads per store, then runs two lanes in parallel, each running three
// dot products, two RW-step square roots side by side (RW = 21 at COORD_WIDTH 16) and a
// 16-step restoring divide. One query is in flight at a time; a finished beat waits in
// the output register while the next item is accepted.
module triplet_angle_compatibility #(
  parameter int MAX_OBJECTS = tac_pkg::MAX_OBJECTS_DEF,
  parameter int MAX_LABELS  = tac_pkg::MAX_LABELS_DEF,
  parameter int COORD_WIDTH = tac_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_command,
  input  logic [5:0]                    in_entry_index,
  input  logic signed [COORD_WIDTH-1:0] in_coord_x,
  input  logic signed [COORD_WIDTH-1:0] in_coord_y,
  input  logic signed [COORD_WIDTH-1:0] in_coord_z,
  input  logic [5:0]                    in_anchor_object,
  input  logic [5:0]                    in_anchor_label,
  input  logic [5:0]                    in_second_object,
  input  logic [5:0]                    in_second_label,
  input  logic [5:0]                    in_third_object,
  input  logic [5:0]                    in_third_label,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [15:0]            out_compat_value,
  output logic                          out_zero_length
);
  import tac_pkg::*;
  `include "triplet_angle_compatibility_macros.svh"

  localparam int OAW = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam int LAW = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int PW  = 3 * COORD_WIDTH;

  top_state_t state_r, state_nxt;

  logic [PW-1:0] obj_mem [MAX_OBJECTS];
  logic [PW-1:0] lab_mem [MAX_LABELS];
  logic [PW-1:0] obj_rd_r, lab_rd_r;
  logic          obj_ok_r, lab_ok_r;
  logic [5:0]    obj_ridx, lab_ridx;

  logic [5:0] i_r, j_r, k_r, l_r, m_r, n_r;
  logic       all_eq_r, some_eq_r;

  logic signed [COORD_WIDTH-1:0] obj_pt [3];
  logic signed [COORD_WIDTH-1:0] lab_pt [3];
  logic signed [COORD_WIDTH-1:0] oa_r [3];
  logic signed [COORD_WIDTH-1:0] ob_r [3];
  logic signed [COORD_WIDTH-1:0] oc_r [3];
  logic signed [COORD_WIDTH-1:0] la_r [3];
  logic signed [COORD_WIDTH-1:0] lb_r [3];
  logic signed [COORD_WIDTH-1:0] lc_r [3];

  lane_ctl_t          lane_ctl;
  lane_status_t       stat_o, stat_l;
  logic signed [15:0] cos_o, cos_l;

  logic               in_acc, out_free;
  logic signed [16:0] diff_c;
  logic signed [15:0] val_c;
  logic               flag_c;
  logic               out_valid_r;
  logic signed [15:0] out_val_r;
  logic               out_flag_r;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: begin
        if (in_acc && in_command == CMD_QUERY) begin
          if ((in_anchor_object == in_second_object) || (in_anchor_object == in_third_object) ||
              (in_second_object == in_third_object) || (in_anchor_label == in_second_label) ||
              (in_anchor_label == in_third_label) || (in_second_label == in_third_label)) begin
            state_nxt = T_FIN;
          end else begin
            state_nxt = T_RD0;
          end
        end
      end
      T_RD0:   state_nxt = T_RD1;
      T_RD1:   state_nxt = T_RD2;
      T_RD2:   state_nxt = T_RD3;
      T_RD3:   state_nxt = T_START;
      T_START: state_nxt = T_WAIT;
      T_WAIT:  if (stat_o.done) state_nxt = T_FIN;
      T_FIN:   if (out_free) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= T_IDLE;
    else        state_r <= state_nxt;
  end

  // query indices and coincidence checks
  always_ff @(posedge clk) begin
    if (in_acc && in_command == CMD_QUERY) begin
      i_r <= in_anchor_object;
      k_r <= in_second_object;
      m_r <= in_third_object;
      j_r <= in_anchor_label;
      l_r <= in_second_label;
      n_r <= in_third_label;
      all_eq_r <= (in_anchor_object == in_second_object) &&
                  (in_anchor_object == in_third_object) &&
                  (in_anchor_label == in_second_label) &&
                  (in_anchor_label == in_third_label);
      some_eq_r <= (in_anchor_object == in_second_object) ||
                   (in_anchor_object == in_third_object) ||
                   (in_second_object == in_third_object) ||
                   (in_anchor_label == in_second_label) ||
                   (in_anchor_label == in_third_label) ||
                   (in_second_label == in_third_label);
    end
  end

  always_comb begin
    unique case (state_r)
      T_RD1:   begin obj_ridx = k_r; lab_ridx = l_r; end
      T_RD2:   begin obj_ridx = m_r; lab_ridx = n_r; end
      default: begin obj_ridx = i_r; lab_ridx = j_r; end
    endcase
  end

  // point stores
  always_ff @(posedge clk) begin
    if (in_acc && in_command == CMD_LOAD_OBJ && 32'(in_entry_index) < MAX_OBJECTS) begin
      obj_mem[OAW'(in_entry_index)] <= {in_coord_z, in_coord_y, in_coord_x};
    end
    obj_rd_r <= obj_mem[OAW'(obj_ridx)];
    obj_ok_r <= 32'(obj_ridx) < MAX_OBJECTS;
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_command == CMD_LOAD_LAB && 32'(in_entry_index) < MAX_LABELS) begin
      lab_mem[LAW'(in_entry_index)] <= {in_coord_z, in_coord_y, in_coord_x};
    end
    lab_rd_r <= lab_mem[LAW'(lab_ridx)];
    lab_ok_r <= 32'(lab_ridx) < MAX_LABELS;
  end

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      obj_pt[t] = obj_ok_r ? obj_rd_r[t*COORD_WIDTH +: COORD_WIDTH] : '0;
      lab_pt[t] = lab_ok_r ? lab_rd_r[t*COORD_WIDTH +: COORD_WIDTH] : '0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      T_RD1:   begin oa_r <= obj_pt; la_r <= lab_pt; end
      T_RD2:   begin ob_r <= obj_pt; lb_r <= lab_pt; end
      T_RD3:   begin oc_r <= obj_pt; lc_r <= lab_pt; end
      default: ;
    endcase
  end

  assign lane_ctl.start = (state_r == T_START);

  tac_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_obj (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lane_ctl),
    .pt_anchor (oa_r),
    .pt_second (ob_r),
    .pt_third  (oc_r),
    .status    (stat_o),
    .cos_q14   (cos_o)
  );

  tac_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_lab (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lane_ctl),
    .pt_anchor (la_r),
    .pt_second (lb_r),
    .pt_third  (lc_r),
    .status    (stat_l),
    .cos_q14   (cos_l)
  );

  always_comb begin
    diff_c = 17'(cos_o) - 17'(cos_l);
    flag_c = 1'b0;
    priority if (all_eq_r) begin
      val_c = '0;
    end else if (some_eq_r) begin
      val_c = MINUS_ONE_Q14;
    end else if (stat_o.zero_len || stat_l.zero_len) begin
      val_c  = MINUS_ONE_Q14;
      flag_c = 1'b1;
    end else if (diff_c > SAT_POS) begin
      val_c = 16'(SAT_POS);
    end else begin
      val_c = 16'(diff_c);
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == T_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == T_FIN && out_free) begin
      out_val_r  <= val_c;
      out_flag_r <= flag_c;
    end
  end

  assign in_stall         = (state_r != T_IDLE);
  assign out_valid        = out_valid_r;
  assign out_compat_value = out_val_r;
  assign out_zero_length  = out_flag_r;

  `TAC_ASSERT_NEXT(a_fin_beat, (state_r == T_FIN) && out_free, out_valid_r, "finished query lost its beat")
  `TAC_ASSERT_NOW(a_lanes_lockstep, stat_o.done, stat_l.done, "lanes out of step")
  `TAC_ASSERT_NEXT(a_query_busy, in_acc && (in_command == CMD_QUERY), state_r != T_IDLE, "query accepted but block idle")
  `TAC_ASSERT_NOW(a_lane_idle_start, lane_ctl.start, state_r == T_START, "lane started outside start state")

endmodule

[design/tac_lane.sv]
module tac_lane #(
  parameter int COORD_WIDTH = tac_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tac_pkg::lane_ctl_t            ctl,
  input  logic signed [COORD_WIDTH-1:0] pt_anchor [3],
  input  logic signed [COORD_WIDTH-1:0] pt_second [3],
  input  logic signed [COORD_WIDTH-1:0] pt_third  [3],
  output tac_pkg::lane_status_t         status,
  output logic signed [15:0]            cos_q14
);
  import tac_pkg::*;

  localparam int SH    = (COORD_WIDTH > 16) ? COORD_WIDTH - 16 : 0;
  localparam int DW    = COORD_WIDTH + 1 - SH;
  localparam int NW    = 2 * DW;
  localparam int SW    = NW + 8;
  localparam int RW    = SW / 2;
  localparam int REMW  = NW + 23;
  localparam int ITMAX = (RW > Q_BITS) ? RW : Q_BITS;
  localparam int ITW   = $clog2(ITMAX);
  localparam logic signed [COORD_WIDTH:0] RND = (COORD_WIDTH + 1)'((1 << SH) - 1);

  lane_state_t state_r, state_nxt;

  logic signed [COORD_WIDTH-1:0] a_r [3];
  logic signed [COORD_WIDTH-1:0] b_r [3];
  logic signed [COORD_WIDTH-1:0] c_r [3];
  logic signed [DW-1:0] v1_r [3];
  logic signed [DW-1:0] v2_r [3];
  logic signed [DW-1:0] v1_nxt [3];
  logic signed [DW-1:0] v2_nxt [3];
  logic signed [DW-1:0] mx [3];
  logic signed [DW-1:0] my [3];
  logic signed [NW-1:0] prod_r [3];
  logic signed [NW-1:0] prod_nxt [3];
  logic signed [NW:0]   sum;
  logic [1:0]           sel_r;
  logic [NW-1:0]        n1_r, n2_r;
  logic signed [NW:0]   dt_r;
  logic [SW-1:0]        sv1_r, sv2_r, sr1_r, sr2_r, bit_r;
  logic [SW:0]          st1, st2;
  logic                 sge1, sge2;
  logic [ITW-1:0]       it_r;
  logic                 zero_r;
  logic [SW-1:0]        den_c;
  logic [NW:0]          absd;
  logic [REMW-1:0]      rem_r, dsh_r;
  logic                 dge;
  logic                 neg_r;
  logic [Q_BITS-1:0]    q_r;
  logic [Q_BITS-1:0]    qmag;
  logic signed [15:0]   cos_r;

  // difference vectors, scaled toward zero for wide coordinates
  always_comb begin
    logic signed [COORD_WIDTH:0] d1, d2;
    for (int t = 0; t < 3; t++) begin
      d1 = (COORD_WIDTH + 1)'(b_r[t]) - (COORD_WIDTH + 1)'(a_r[t]);
      d2 = (COORD_WIDTH + 1)'(c_r[t]) - (COORD_WIDTH + 1)'(a_r[t]);
      if (d1[COORD_WIDTH]) d1 = d1 + RND;
      if (d2[COORD_WIDTH]) d2 = d2 + RND;
      v1_nxt[t] = DW'(d1 >>> SH);
      v2_nxt[t] = DW'(d2 >>> SH);
    end
  end

  always_comb begin
    for (int t = 0; t < 3; t++) begin
      unique case (sel_r)
        2'd0:    begin mx[t] = v1_r[t]; my[t] = v1_r[t]; end
        2'd1:    begin mx[t] = v2_r[t]; my[t] = v2_r[t]; end
        default: begin mx[t] = v1_r[t]; my[t] = v2_r[t]; end
      endcase
      prod_nxt[t] = mx[t] * my[t];
    end
    sum = (NW + 1)'(prod_r[0]) + (NW + 1)'(prod_r[1]) + (NW + 1)'(prod_r[2]);
  end

  always_comb begin
    st1   = {1'b0, sr1_r} + {1'b0, bit_r};
    st2   = {1'b0, sr2_r} + {1'b0, bit_r};
    sge1  = {1'b0, sv1_r} >= st1;
    sge2  = {1'b0, sv2_r} >= st2;
    den_c = sr1_r[RW-1:0] * sr2_r[RW-1:0];
    absd  = dt_r[NW] ? -dt_r : dt_r;
    dge   = rem_r >= dsh_r;
    qmag  = (q_r > Q_BITS'(ONE_Q14)) ? Q_BITS'(ONE_Q14) : q_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      L_IDLE: if (ctl.start) state_nxt = L_DIFF;
      L_DIFF: state_nxt = L_MUL;
      L_MUL:  state_nxt = L_SUM;
      L_SUM:  state_nxt = (sel_r == 2'd2) ? L_SQRT : L_MUL;
      L_SQRT: if (it_r == ITW'(RW - 1)) state_nxt = L_DEN;
      L_DEN:  state_nxt = L_DIV;
      L_DIV:  if (it_r == ITW'(Q_BITS - 1)) state_nxt = L_DONE;
      L_DONE: state_nxt = L_IDLE;
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= L_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      L_IDLE: begin
        if (ctl.start) begin
          a_r <= pt_anchor;
          b_r <= pt_second;
          c_r <= pt_third;
        end
      end
      L_DIFF: begin
        v1_r  <= v1_nxt;
        v2_r  <= v2_nxt;
        sel_r <= 2'd0;
      end
      L_MUL: prod_r <= prod_nxt;
      L_SUM: begin
        unique case (sel_r)
          2'd0:    n1_r <= NW'(sum);
          2'd1:    n2_r <= NW'(sum);
          default: dt_r <= sum;
        endcase
        sel_r <= sel_r + 2'd1;
        if (sel_r == 2'd2) begin
          sv1_r  <= {n1_r, 8'd0};
          sv2_r  <= {n2_r, 8'd0};
          sr1_r  <= '0;
          sr2_r  <= '0;
          bit_r  <= SW'(1) << (SW - 2);
          it_r   <= '0;
          zero_r <= (n1_r == '0) || (n2_r == '0);
        end
      end
      L_SQRT: begin
        if (sge1) begin
          sv1_r <= sv1_r - st1[SW-1:0];
          sr1_r <= (sr1_r >> 1) + bit_r;
        end else begin
          sr1_r <= sr1_r >> 1;
        end
        if (sge2) begin
          sv2_r <= sv2_r - st2[SW-1:0];
          sr2_r <= (sr2_r >> 1) + bit_r;
        end else begin
          sr2_r <= sr2_r >> 1;
        end
        bit_r <= bit_r >> 2;
        it_r  <= it_r + ITW'(1);
      end
      L_DEN: begin
        dsh_r <= REMW'(den_c) << (Q_BITS - 1);
        rem_r <= REMW'(absd) << 22;
        neg_r <= dt_r[NW];
        q_r   <= '0;
        it_r  <= '0;
      end
      L_DIV: begin
        if (dge) rem_r <= rem_r - dsh_r;
        q_r   <= {q_r[Q_BITS-2:0], dge};
        dsh_r <= dsh_r >> 1;
        it_r  <= it_r + ITW'(1);
      end
      L_DONE: cos_r <= neg_r ? -$signed(qmag) : $signed(qmag);
      default: ;
    endcase
  end

  always_comb begin
    status.done     = (state_r == L_DONE);
    status.zero_len = zero_r;
    cos_q14         = cos_r;
  end

endmodule
